// ===== rtl/wrcm_pkg.sv =====
// Shared types, sizes and register codes for the windowed RMS current meter.
// No dependencies; every other file of the block refers to this package by scope.
`default_nettype none

package wrcm_pkg;

    // Data path sizes
    localparam int ADC_BITS    = 12;
    localparam int WINDOW_BITS = 12;
    localparam int SUM_W       = 37;
    localparam int FRAC_BITS   = 8;
    // mean is shifted left by two fraction widths before the root
    localparam int RAD_IN_W    = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_W      = (RAD_IN_W + 1) / 2;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int RMS_W       = 20;
    localparam int CUR_W       = 16;
    localparam int PWR_W       = 26;
    localparam int SMP_TMR_W   = 8;
    localparam int WIN_TMR_W   = 12;
    localparam int GAIN_W      = 16;
    localparam int PGAIN_W     = 10;
    localparam int MUL_A_W     = 20;
    localparam int MUL_B_W     = 16;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_CNT_W   = $clog2(SUM_W);
    localparam int SQ_CNT_W    = $clog2(ROOT_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ADC_OFFSET      = 3'd0;
    localparam cfg_idx_t REG_SAMPLE_INTERVAL = 3'd1;
    localparam cfg_idx_t REG_WINDOW_LENGTH   = 3'd2;
    localparam cfg_idx_t REG_CURRENT_GAIN    = 3'd3;
    localparam cfg_idx_t REG_DEADBAND_MA     = 3'd4;
    localparam cfg_idx_t REG_POWER_GAIN      = 3'd5;

    // Register reset values
    localparam logic [ADC_BITS-1:0]  RST_ADC_OFFSET      = 12'd2048;
    localparam logic [SMP_TMR_W-1:0] RST_SAMPLE_INTERVAL = 8'd1;
    localparam logic [WIN_TMR_W-1:0] RST_WINDOW_LENGTH   = 12'd200;
    localparam logic [GAIN_W-1:0]    RST_CURRENT_GAIN    = 16'd6190;
    localparam logic [CUR_W-1:0]     RST_DEADBAND_MA     = 16'd120;
    localparam logic [PGAIN_W-1:0]   RST_POWER_GAIN      = 10'd198;

    // Input item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [RAD_W-1:0] rad_t;

    typedef struct packed {
        logic                kind;
        logic [ADC_BITS-1:0] adc_sample;
    } in_t;

    typedef struct packed {
        logic [RMS_W-1:0]       rms_counts;
        logic [CUR_W-1:0]       current_ma;
        logic [PWR_W-1:0]       power_mw;
        logic [WINDOW_BITS-1:0] samples_used;
        logic                   in_deadband;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/windowed_rms_current_meter.sv =====
// Windowed true-RMS current meter: sequencer, shared multiplier, accumulators.
// Depends on wrcm_pkg, wrcm_div and wrcm_sqrt.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one beat per millisecond tick
//    carrying an ADC sample, or a restart beat that clears timers and sums.
//  - Output channel (out_valid/out_stall/out_data): one beat per closed window
//    that held at least one sample: RMS in Q12.8 counts, current in mA after
//    the deadband, power in mW, sample count and the deadband flag.
//  - Config port (cfg_we/cfg_index/cfg_data): write while the block is idle.
//  - Sequence: a restart beat is taken without leaving idle; a tick that does
//    not close the window passes accept, multiply and accumulate; one that
//    closes an empty window adds the close step. A close with samples adds
//    the bit-serial divider and square root, then current and power steps
//    and the result beat. in_stall is high whenever the sequencer is not idle.
//  - The finished result sits in an output register; new ticks are taken
//    while it waits. A later window close waits in its last step until the
//    output register is free, holding in_stall high.
//  - Reset: registers go to their defaults, timers and sums to zero, and the
//    output channel is empty.
`default_nettype none

module windowed_rms_current_meter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire wrcm_pkg::in_t                       in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output wrcm_pkg::out_t                           out_data,
    input  wire logic                                cfg_we,
    input  wire wrcm_pkg::cfg_idx_t                  cfg_index,
    input  wire logic [wrcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULSQ,
        ST_ACC,
        ST_CLOSE,
        ST_DIV,
        ST_SQRT,
        ST_MULC,
        ST_CUR,
        ST_MULP,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [wrcm_pkg::ADC_BITS-1:0]   adc_offset_reg;
    logic [wrcm_pkg::SMP_TMR_W-1:0]  sample_interval_reg;
    logic [wrcm_pkg::WIN_TMR_W-1:0]  window_length_reg;
    logic [wrcm_pkg::GAIN_W-1:0]     current_gain_reg;
    logic [wrcm_pkg::CUR_W-1:0]      deadband_reg;
    logic [wrcm_pkg::PGAIN_W-1:0]    power_gain_reg;

    // Window state
    logic [wrcm_pkg::SMP_TMR_W-1:0]    sample_timer_reg;
    logic [wrcm_pkg::WIN_TMR_W-1:0]    window_timer_reg;
    wrcm_pkg::sum_t                    sum_reg;
    logic [wrcm_pkg::WINDOW_BITS-1:0]  count_reg;

    // Per-item working registers
    logic                              take_reg;
    logic                              close_reg;
    logic [wrcm_pkg::ADC_BITS-1:0]     mag_reg;
    logic [wrcm_pkg::MUL_P_W-1:0]      prod_reg;
    logic [wrcm_pkg::RMS_W-1:0]        rms_reg;
    logic [wrcm_pkg::CUR_W-1:0]        cur_reg;
    logic                              dead_reg;
    logic [wrcm_pkg::WINDOW_BITS-1:0]  samples_reg;

    logic                              out_valid_reg;
    wrcm_pkg::out_t                    out_reg;

    logic                              in_accept;
    logic                              out_take;
    logic                              div_start;
    logic                              div_done;
    wrcm_pkg::sum_t                    div_quo;
    logic                              sq_start;
    logic                              sq_done;
    logic [wrcm_pkg::ROOT_W-1:0]       sq_root;

    logic [wrcm_pkg::SMP_TMR_W-1:0]    smp_tmr_inc;
    logic [wrcm_pkg::WIN_TMR_W-1:0]    win_tmr_inc;
    logic                              take_now;
    logic                              close_now;
    logic [wrcm_pkg::ADC_BITS-1:0]     mag_now;

    logic [wrcm_pkg::MUL_A_W-1:0]      mul_a;
    logic [wrcm_pkg::MUL_B_W-1:0]      mul_b;
    logic [wrcm_pkg::MUL_P_W-1:0]      mul_p;

    logic [wrcm_pkg::SUM_W:0]          sum_add;
    wrcm_pkg::sum_t                    sum_next;
    logic [wrcm_pkg::WINDOW_BITS-1:0]  count_next;
    logic [wrcm_pkg::RMS_W-1:0]        rms_sat;
    logic [wrcm_pkg::CUR_W-1:0]        cur_sat;
    logic                              dead_now;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Tick timers and centred sample magnitude
    always_comb
    begin
        smp_tmr_inc = sample_timer_reg + 1'b1;
        win_tmr_inc = window_timer_reg + 1'b1;
        take_now    = (smp_tmr_inc >= sample_interval_reg);
        close_now   = (win_tmr_inc >= window_length_reg);
        mag_now     = (in_data.adc_sample >= adc_offset_reg)
                    ? in_data.adc_sample - adc_offset_reg
                    : adc_offset_reg - in_data.adc_sample;
    end

    // Shared multiplier: square, current scaling, power scaling
    always_comb
    begin
        case (state_reg)
            ST_MULSQ:
            begin
                mul_a = wrcm_pkg::MUL_A_W'(mag_reg);
                mul_b = wrcm_pkg::MUL_B_W'(mag_reg);
            end
            ST_MULC:
            begin
                mul_a = rms_reg;
                mul_b = current_gain_reg;
            end
            ST_MULP:
            begin
                mul_a = wrcm_pkg::MUL_A_W'(cur_reg);
                mul_b = wrcm_pkg::MUL_B_W'(power_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Saturating accumulate, root clamp, current clamp and deadband
    always_comb
    begin
        sum_add    = {1'b0, sum_reg} + (wrcm_pkg::SUM_W + 1)'(prod_reg);
        sum_next   = sum_add[wrcm_pkg::SUM_W] ? '1 : sum_add[wrcm_pkg::SUM_W-1:0];
        count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        rms_sat    = (|sq_root[wrcm_pkg::ROOT_W-1:wrcm_pkg::RMS_W]) ? '1
                   : sq_root[wrcm_pkg::RMS_W-1:0];
        cur_sat    = (|prod_reg[wrcm_pkg::MUL_P_W-1:wrcm_pkg::CUR_W+16]) ? '1
                   : prod_reg[wrcm_pkg::CUR_W+15:16];
        dead_now   = (cur_sat < deadband_reg);
    end

    assign div_start = (state_reg == ST_CLOSE) && (count_reg != '0);
    assign sq_start  = (state_reg == ST_DIV) && div_done;

    wrcm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    wrcm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .mean  (div_quo),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_offset_reg      <= wrcm_pkg::RST_ADC_OFFSET;
            sample_interval_reg <= wrcm_pkg::RST_SAMPLE_INTERVAL;
            window_length_reg   <= wrcm_pkg::RST_WINDOW_LENGTH;
            current_gain_reg    <= wrcm_pkg::RST_CURRENT_GAIN;
            deadband_reg        <= wrcm_pkg::RST_DEADBAND_MA;
            power_gain_reg      <= wrcm_pkg::RST_POWER_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wrcm_pkg::REG_ADC_OFFSET:
                    adc_offset_reg <= cfg_data[wrcm_pkg::ADC_BITS-1:0];
                wrcm_pkg::REG_SAMPLE_INTERVAL:
                    sample_interval_reg <= cfg_data[wrcm_pkg::SMP_TMR_W-1:0];
                wrcm_pkg::REG_WINDOW_LENGTH:
                    window_length_reg <= cfg_data[wrcm_pkg::WIN_TMR_W-1:0];
                wrcm_pkg::REG_CURRENT_GAIN:
                    current_gain_reg <= cfg_data[wrcm_pkg::GAIN_W-1:0];
                wrcm_pkg::REG_DEADBAND_MA:
                    deadband_reg <= cfg_data[wrcm_pkg::CUR_W-1:0];
                wrcm_pkg::REG_POWER_GAIN:
                    power_gain_reg <= cfg_data[wrcm_pkg::PGAIN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Sequencer with window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_timer_reg <= '0;
            window_timer_reg <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            take_reg         <= 1'b0;
            close_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // ST_EMIT refills the output register in the cycle it drains
            if (out_take && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (in_data.kind == wrcm_pkg::KIND_RESTART)
                        begin
                            sample_timer_reg <= '0;
                            window_timer_reg <= '0;
                            sum_reg          <= '0;
                            count_reg        <= '0;
                        end
                        else
                        begin
                            sample_timer_reg <= take_now ? '0 : smp_tmr_inc;
                            window_timer_reg <= close_now ? '0 : win_tmr_inc;
                            take_reg         <= take_now;
                            close_reg        <= close_now;
                            state_reg        <= ST_MULSQ;
                        end
                    end
                end
                ST_MULSQ:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (take_reg)
                    begin
                        sum_reg   <= sum_next;
                        count_reg <= count_next;
                    end
                    state_reg <= close_reg ? ST_CLOSE : ST_IDLE;
                end
                ST_CLOSE:
                begin
                    // Divider has latched the operands; accumulators restart
                    sum_reg   <= '0;
                    count_reg <= '0;
                    state_reg <= (count_reg != '0) ? ST_DIV : ST_IDLE;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_MULC;
                    end
                end
                ST_MULC:
                begin
                    state_reg <= ST_CUR;
                end
                ST_CUR:
                begin
                    state_reg <= ST_MULP;
                end
                ST_MULP:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || out_take)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mag_reg <= mag_now;
        end
        if (state_reg == ST_MULSQ || state_reg == ST_MULC || state_reg == ST_MULP)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_CLOSE)
        begin
            samples_reg <= count_reg;
        end
        if (state_reg == ST_SQRT && sq_done)
        begin
            rms_reg <= rms_sat;
        end
        if (state_reg == ST_CUR)
        begin
            cur_reg  <= dead_now ? '0 : cur_sat;
            dead_reg <= dead_now;
        end
        if (state_reg == ST_EMIT && (!out_valid_reg || out_take))
        begin
            out_reg.rms_counts   <= rms_reg;
            out_reg.current_ma   <= cur_reg;
            out_reg.power_mw     <= prod_reg[wrcm_pkg::PWR_W-1:0];
            out_reg.samples_used <= samples_reg;
            out_reg.in_deadband  <= dead_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wrcm_div.sv =====
// Restoring divider, one quotient bit per cycle: sum of squares by sample count.
// Depends on wrcm_pkg for sizes.
`default_nettype none

module wrcm_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire wrcm_pkg::sum_t                      dividend,
    input  wire logic [wrcm_pkg::WINDOW_BITS-1:0]    divisor,
    output logic                                     done,
    output wrcm_pkg::sum_t                           quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [wrcm_pkg::DIV_CNT_W-1:0]     step_reg;
    logic [wrcm_pkg::WINDOW_BITS-1:0]   div_reg;
    logic [wrcm_pkg::WINDOW_BITS-1:0]   rem_reg;
    wrcm_pkg::sum_t                     quo_reg;

    logic [wrcm_pkg::WINDOW_BITS:0]     rem_sh;
    logic [wrcm_pkg::WINDOW_BITS:0]     rem_diff;
    logic                               ge;
    logic [wrcm_pkg::WINDOW_BITS-1:0]   rem_next;
    wrcm_pkg::sum_t                     quo_next;

    // One trial subtraction; remainder stays below the divisor
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[wrcm_pkg::SUM_W-1]};
        rem_diff = rem_sh - {1'b0, div_reg};
        ge       = (rem_sh >= {1'b0, div_reg});
        rem_next = ge ? rem_diff[wrcm_pkg::WINDOW_BITS-1:0]
                      : rem_sh[wrcm_pkg::WINDOW_BITS-1:0];
        quo_next = {quo_reg[wrcm_pkg::SUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= wrcm_pkg::DIV_CNT_W'(wrcm_pkg::SUM_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/wrcm_sqrt.sv =====
// Digit-by-digit integer square root of mean << 16, one root bit per cycle.
// Depends on wrcm_pkg for sizes.
`default_nettype none

module wrcm_sqrt (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire wrcm_pkg::sum_t                   mean,
    output logic                                  done,
    output logic [wrcm_pkg::ROOT_W-1:0]           root
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [wrcm_pkg::SQ_CNT_W-1:0]     step_reg;
    wrcm_pkg::rad_t                    rad_reg;
    logic [wrcm_pkg::ROOT_W-1:0]       rem_reg;
    logic [wrcm_pkg::ROOT_W-1:0]       root_reg;

    logic [wrcm_pkg::ROOT_W+1:0]       rem_sh;
    logic [wrcm_pkg::ROOT_W+1:0]       trial;
    logic [wrcm_pkg::ROOT_W+1:0]       rem_diff;
    logic                              ge;

    // Bring down two radicand bits and try root*4+1
    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[wrcm_pkg::RAD_W-1 -: 2]};
        trial    = {1'b0, root_reg[wrcm_pkg::ROOT_W-2:0], 2'b01};
        rem_diff = rem_sh - trial;
        ge       = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= wrcm_pkg::SQ_CNT_W'(wrcm_pkg::ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder stays below 2^ROOT_W until the last step, whose remainder is unused
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= wrcm_pkg::rad_t'({mean, {(2 * wrcm_pkg::FRAC_BITS){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[wrcm_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_diff[wrcm_pkg::ROOT_W-1:0] : rem_sh[wrcm_pkg::ROOT_W-1:0];
            root_reg <= {root_reg[wrcm_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire
